// File: sv/ogm_pkg.sv
// Shared types, constants and helper functions of the occupancy grid marker.
// Used by the channel interfaces, the register block and the sequencer.
package ogm_pkg;

  // Field and register widths
  localparam int EXT_W      = 9;
  localparam int IN_W       = 10;
  localparam int MARGIN_W   = 6;
  localparam int CAP_W      = 13;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Grid size defaults
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Register reset values
  localparam logic [EXT_W-1:0]    MAP_WIDTH_RST  = 9'd256;
  localparam logic [EXT_W-1:0]    MAP_HEIGHT_RST = 9'd256;
  localparam logic [MARGIN_W-1:0] MARGIN_RST     = 6'd10;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MARGIN     = 2'd2;

  // Request function codes
  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  typedef struct packed {
    logic [EXT_W-1:0]    map_width;
    logic [EXT_W-1:0]    map_height;
    logic [MARGIN_W-1:0] margin;
  } cfg_t;

  // Extent in use: zero counts as one, above the grid size saturates
  function automatic logic [EXT_W-1:0] used_extent(input logic [EXT_W-1:0] val,
                                                   input logic [CAP_W-1:0] cap);
    logic [EXT_W-1:0] res;
    if (val == '0) begin
      res = EXT_W'(1);
    end else if ({{(CAP_W-EXT_W){1'b0}}, val} > cap) begin
      res = cap[EXT_W-1:0];
    end else begin
      res = val;
    end
    return res;
  endfunction

  // Saturate a coordinate to the last column or row in use
  function automatic logic [EXT_W-1:0] clamp_coord(input logic [IN_W-1:0]  v,
                                                   input logic [EXT_W-1:0] ext);
    logic [EXT_W-1:0] res;
    if (v >= {1'b0, ext}) begin
      res = ext - EXT_W'(1);
    end else begin
      res = v[EXT_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: sv/ogm_if.sv
// Request and response channel interfaces of the occupancy grid marker.
// Depends on ogm_pkg for the field widths.
interface ogm_req_if import ogm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            func;
  logic [IN_W-1:0] x_coord;
  logic [IN_W-1:0] y_coord;

  modport source (output valid, func, x_coord, y_coord, input ready);
  modport sink   (input valid, func, x_coord, y_coord, output ready);
endinterface

interface ogm_rsp_if import ogm_pkg::*; ();
  logic valid;
  logic ready;
  logic center_free;
  logic area_marked;

  modport source (output valid, center_free, area_marked, input ready);
  modport sink   (input valid, center_free, area_marked, output ready);
endinterface

// File: sv/ogm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ogm_ram #(
  parameter int WIDTH  = 1,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write through the port, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/ogm_regs.sv
// APB configuration registers: map width, map height and margin.
// Depends on ogm_pkg for the register layout and reset values.
module ogm_regs import ogm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Update the addressed register on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width  <= MAP_WIDTH_RST;
      cfg.map_height <= MAP_HEIGHT_RST;
      cfg.margin     <= MARGIN_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_MAP_WIDTH:  cfg.map_width  <= pwdata[EXT_W-1:0];
        REG_MAP_HEIGHT: cfg.map_height <= pwdata[EXT_W-1:0];
        REG_MARGIN:     cfg.margin     <= pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_MAP_WIDTH:  prdata = APB_DATA_W'(cfg.map_width);
      REG_MAP_HEIGHT: prdata = APB_DATA_W'(cfg.map_height);
      REG_MARGIN:     prdata = APB_DATA_W'(cfg.margin);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: sv/ogm_addr_gen.sv
// Shared address unit: turns a column and row into a grid cell address.
// Depends on ogm_pkg for the coordinate width.
module ogm_addr_gen import ogm_pkg::*; #(
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int ADDR_W     = 16
) (
  input  logic [EXT_W-1:0]  col,
  input  logic [EXT_W-1:0]  row,
  output logic [ADDR_W-1:0] addr
);

  // Column-major layout: col * MAX_HEIGHT + row
  assign addr = ADDR_W'(col) * ADDR_W'(MAX_HEIGHT) + ADDR_W'(row);

endmodule

// File: sv/occupancy_grid_obstacle_marker_unit.sv
// Occupancy grid obstacle marker. After reset the block sweeps the whole grid
// to free, one cell a cycle (MAX_WIDTH*MAX_HEIGHT cells, 65536 by default),
// and takes no request until the sweep is done; register writes work at once.
// A request then passes through accept, centre read and decide; a mark on a free
// centre next writes each cell of the clipped square, up to (2*margin)^2 cells,
// one at a time through the single port of the grid RAM, and the result is then
// loaded once the output slot is free. One request is in flight at a time.
module occupancy_grid_obstacle_marker_unit import ogm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  ogm_req_if.sink               req,
  ogm_rsp_if.source             rsp
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WALK,
    S_DONE
  } state_t;

  state_t            state;
  cfg_t              cfg;
  logic [ADDR_W-1:0] clr_cnt;
  logic              func_q;
  logic [EXT_W-1:0]  x_q, y_q;
  logic [EXT_W-1:0]  col, row, col_lo, row_lo, col_hi, row_hi;
  logic              free_q, marked_q;
  logic              rsp_valid, rsp_free, rsp_marked;

  logic [EXT_W-1:0]  ext_w, ext_h;
  logic [EXT_W:0]    sum_c, sum_r;
  logic [EXT_W-1:0]  col_lo_c, row_lo_c, col_hi_c, row_hi_c;
  logic [EXT_W-1:0]  margin_ext;
  logic              nonempty, do_mark;
  logic [EXT_W-1:0]  ag_col, ag_row;
  logic [ADDR_W-1:0] ag_addr, ram_addr;
  logic              ram_we;
  logic [0:0]        ram_wdata, ram_rdata;

  ogm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Extents in use
  assign ext_w = used_extent(cfg.map_width, CAP_W'(MAX_WIDTH));
  assign ext_h = used_extent(cfg.map_height, CAP_W'(MAX_HEIGHT));

  // Clipped square bounds from the latched centre
  assign margin_ext = EXT_W'(cfg.margin);
  assign sum_c      = {1'b0, x_q} + {1'b0, margin_ext};
  assign sum_r      = {1'b0, y_q} + {1'b0, margin_ext};
  assign col_hi_c   = (sum_c > {1'b0, ext_w}) ? ext_w : sum_c[EXT_W-1:0];
  assign row_hi_c   = (sum_r > {1'b0, ext_h}) ? ext_h : sum_r[EXT_W-1:0];
  assign col_lo_c   = (x_q >= margin_ext) ? x_q - margin_ext : '0;
  assign row_lo_c   = (y_q >= margin_ext) ? y_q - margin_ext : '0;
  assign nonempty   = (col_lo_c < col_hi_c) && (row_lo_c < row_hi_c);
  assign do_mark    = (func_q == FUNC_MARK) && !ram_rdata[0];

  // Address unit walks the square, otherwise points at the centre
  assign ag_col = (state == S_WALK) ? col : x_q;
  assign ag_row = (state == S_WALK) ? row : y_q;

  ogm_addr_gen #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .ADDR_W     (ADDR_W)
  ) u_addr_gen (
    .col  (ag_col),
    .row  (ag_row),
    .addr (ag_addr)
  );

  // Grid RAM port control
  assign ram_addr  = (state == S_CLEAR) ? clr_cnt : ag_addr;
  assign ram_we    = (state == S_CLEAR) || (state == S_WALK);
  assign ram_wdata = (state == S_WALK) ? 1'b1 : 1'b0;

  ogm_ram #(
    .WIDTH  (1),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.center_free = rsp_free;
  assign rsp.area_marked = rsp_marked;

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the result once the sink takes the beat
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
          if (clr_cnt == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            func_q <= req.func;
            x_q    <= clamp_coord(req.x_coord, ext_w);
            y_q    <= clamp_coord(req.y_coord, ext_h);
            state  <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          free_q   <= !ram_rdata[0];
          marked_q <= do_mark;
          col      <= col_lo_c;
          row      <= row_lo_c;
          col_lo   <= col_lo_c;
          row_lo   <= row_lo_c;
          col_hi   <= col_hi_c;
          row_hi   <= row_hi_c;
          state    <= (do_mark && nonempty) ? S_WALK : S_DONE;
        end
        S_WALK: begin
          // Advance row first, then column
          if ((row + EXT_W'(1)) == row_hi) begin
            row <= row_lo;
            if ((col + EXT_W'(1)) == col_hi) begin
              state <= S_DONE;
            end else begin
              col <= col + EXT_W'(1);
            end
          end else begin
            row <= row + EXT_W'(1);
          end
        end
        S_DONE: begin
          // Load the result once the output slot is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_free   <= free_q;
            rsp_marked <= marked_q;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_occupancy_grid_obstacle_marker_unit.sv
// Self-checking testbench for the occupancy grid obstacle marker unit.
// Depends on ogm_pkg, the ogm_req_if/ogm_rsp_if interfaces and the unit itself;
// a local grid model predicts every response and a monitor compares them.
module tb_occupancy_grid_obstacle_marker_unit;
  import ogm_pkg::*;

  localparam int GRID_COLS    = DEF_MAX_WIDTH;
  localparam int GRID_ROWS    = DEF_MAX_HEIGHT;
  localparam int RANDOM_ITEMS = 1050;

  typedef struct packed {
    logic            func;
    logic [IN_W-1:0] x_coord;
    logic [IN_W-1:0] y_coord;
  } grid_req_t;

  typedef struct packed {
    logic center_free;
    logic area_marked;
  } grid_rsp_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ogm_req_if req_ch ();
  ogm_rsp_if rsp_ch ();

  occupancy_grid_obstacle_marker_unit dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  // Grid model and its copy of the registers
  bit occ_grid [GRID_COLS*GRID_ROWS];
  int cfg_width  = int'(MAP_WIDTH_RST);
  int cfg_height = int'(MAP_HEIGHT_RST);
  int cfg_margin = int'(MARGIN_RST);

  grid_req_t pending_reqs [$];
  grid_rsp_t expected_rsp [$];
  grid_req_t cur_req;
  grid_rsp_t got_rsp;
  grid_rsp_t want_rsp;

  // Beat counters and run statistics
  int  queued_reqs   = 0;
  int  req_beats     = 0;
  int  rsp_beats     = 0;
  int  random_reqs   = 0;
  int  check_reqs    = 0;
  int  areas_set     = 0;
  int  blocked_cells = 0;
  int  map_settings  = 0;
  int  mismatches    = 0;

  // Sender and receiver pacing
  bit       beat_taken = 0;
  int       gap_left   = 0;
  int       burst_left = 1;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  int       rx_tick    = 0;

  // Last mark position, used to probe the edges of the marked square
  bit have_last_mark = 0;
  int last_mark_x    = 0;
  int last_mark_y    = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR: %s (response %0d)", msg, rsp_beats);
    mismatches++;
  endtask

  // Extent in use: zero counts as one, anything above the grid saturates
  function automatic int extent_in_use(input int reg_val, input int cap);
    if (reg_val == 0) return 1;
    if (reg_val > cap) return cap;
    return reg_val;
  endfunction

  // Predict one response and apply the mark to the grid model
  function automatic grid_rsp_t predict_response(input grid_req_t rq);
    int w, h, x, y, c_lo, c_hi, r_lo, r_hi, c, r;
    grid_rsp_t rs;
    w = extent_in_use(cfg_width, GRID_COLS);
    h = extent_in_use(cfg_height, GRID_ROWS);
    x = (int'(rq.x_coord) >= w) ? w - 1 : int'(rq.x_coord);
    y = (int'(rq.y_coord) >= h) ? h - 1 : int'(rq.y_coord);
    rs.center_free = !occ_grid[x*GRID_ROWS + y];
    rs.area_marked = 1'b0;
    if (rq.func == FUNC_MARK && rs.center_free) begin
      c_lo = (x >= cfg_margin) ? x - cfg_margin : 0;
      r_lo = (y >= cfg_margin) ? y - cfg_margin : 0;
      c_hi = (x + cfg_margin > w) ? w : x + cfg_margin;
      r_hi = (y + cfg_margin > h) ? h : y + cfg_margin;
      for (c = c_lo; c < c_hi; c++)
        for (r = r_lo; r < r_hi; r++)
          occ_grid[c*GRID_ROWS + r] = 1'b1;
      rs.area_marked = 1'b1;
    end
    return rs;
  endfunction

  // Mostly inside the map, with edges and out-of-range values mixed in
  function automatic logic [IN_W-1:0] random_coord(input int ext);
    case ($urandom_range(0, 9))
      7:       return IN_W'(ext - 1);
      8:       return IN_W'($urandom_range(0, 1023));
      9:       return IN_W'($urandom_range(ext, 1023));
      default: return IN_W'($urandom_range(0, ext - 1));
    endcase
  endfunction

  // Land on or just past the boundary of the last marked square
  function automatic logic [IN_W-1:0] probe_coord(input int center);
    int v;
    v = center - cfg_margin - 1 + int'($urandom_range(0, 2*cfg_margin + 1));
    return IN_W'((v < 0) ? 0 : v);
  endfunction

  function automatic grid_req_t random_request();
    int w, h;
    grid_req_t rq;
    w = extent_in_use(cfg_width, GRID_COLS);
    h = extent_in_use(cfg_height, GRID_ROWS);
    rq.func = ($urandom_range(0, 1) == 0) ? FUNC_MARK : FUNC_CHECK;
    if (have_last_mark && $urandom_range(0, 9) < 3) begin
      rq.x_coord = probe_coord(last_mark_x);
      rq.y_coord = probe_coord(last_mark_y);
    end else begin
      rq.x_coord = random_coord(w);
      rq.y_coord = random_coord(h);
    end
    if (rq.func == FUNC_MARK) begin
      have_last_mark = 1;
      last_mark_x    = (int'(rq.x_coord) >= w) ? w - 1 : int'(rq.x_coord);
      last_mark_y    = (int'(rq.y_coord) >= h) ? h - 1 : int'(rq.y_coord);
    end
    return rq;
  endfunction

  // Register value with the extremes weighted up
  function automatic int random_extent();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 1;
      2:       return 256;
      3:       return int'($urandom_range(257, 511));
      default: return int'($urandom_range(1, 256));
    endcase
  endfunction

  task automatic queue_request(input grid_req_t rq);
    pending_reqs.push_back(rq);
    queued_reqs++;
  endtask

  // Wait until every queued request is taken and answered; ends on a falling edge
  task automatic wait_drained();
    @(negedge clk);
    while (req_beats != queued_reqs || rsp_beats != req_beats) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle held until pready
  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MAP_WIDTH:  cfg_width  = value & 'h1FF;
      REG_MAP_HEIGHT: cfg_height = value & 'h1FF;
      REG_MARGIN:     cfg_margin = value & 'h3F;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_map(input int w, input int h, input int m);
    write_reg(REG_MAP_WIDTH, w);
    write_reg(REG_MAP_HEIGHT, h);
    write_reg(REG_MARGIN, m);
    map_settings++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Request side: record each accepted beat and predict its response
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_rsp.push_back(predict_response(cur_req));
      if (cur_req.func == FUNC_CHECK) check_reqs++;
      req_beats++;
      beat_taken = 1;
    end
  end

  // Driver: bursts of beats separated by random gaps
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid   <= 1'b0;
      req_ch.func    <= FUNC_MARK;
      req_ch.x_coord <= '0;
      req_ch.y_coord <= '0;
    end else if (!req_ch.valid || beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        req_ch.valid   <= 1'b1;
        req_ch.func    <= cur_req.func;
        req_ch.x_coord <= cur_req.x_coord;
        req_ch.y_coord <= cur_req.y_coord;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 10);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
    beat_taken = 0;
  end

  // Receiver: switch between open, random and periodic stall patterns
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_left = $urandom_range(32, 256);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_OPEN:   rsp_ch.ready <= 1'b1;
        RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default:   rsp_ch.ready <= (rx_tick % 8 < 5);
      endcase
      rx_tick++;
    end
  end

  // Monitor: compare each response beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_rsp.center_free = rsp_ch.center_free;
      got_rsp.area_marked = rsp_ch.area_marked;
      if (expected_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (got_rsp.center_free !== want_rsp.center_free)
          report_mismatch($sformatf("center_free got %b want %b",
                                    got_rsp.center_free, want_rsp.center_free));
        if (got_rsp.area_marked !== want_rsp.area_marked)
          report_mismatch($sformatf("area_marked got %b want %b",
                                    got_rsp.area_marked, want_rsp.area_marked));
      end
      if (got_rsp.area_marked === 1'b1) areas_set++;
      if (got_rsp.center_free === 1'b0) blocked_cells++;
      rsp_beats++;
    end
  end

  // Stimulus sequence
  initial begin
    int n, wv, hv, mv;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.func  = FUNC_MARK;
    req_ch.x_coord = '0;
    req_ch.y_coord = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: clipping at the low corner, occupied centers, clamping
    @(posedge clk);
    queue_request('{FUNC_CHECK, 10'd0,    10'd0});
    queue_request('{FUNC_MARK,  10'd0,    10'd0});
    queue_request('{FUNC_CHECK, 10'd9,    10'd9});
    queue_request('{FUNC_CHECK, 10'd10,   10'd0});
    queue_request('{FUNC_MARK,  10'd5,    10'd5});
    queue_request('{FUNC_MARK,  10'd1023, 10'd1023});
    queue_request('{FUNC_CHECK, 10'd255,  10'd246});
    queue_request('{FUNC_CHECK, 10'd244,  10'd255});
    queue_request('{FUNC_MARK,  10'd600,  10'd128});

    // Zero width and height collapse the map to one cell
    wait_drained();
    set_map(0, 0, 0);
    @(posedge clk);
    queue_request('{FUNC_CHECK, 10'd1023, 10'd1023});
    queue_request('{FUNC_MARK,  10'd7,    10'd3});

    // Oversized extents saturate; zero margin marks nothing
    wait_drained();
    set_map(511, 511, 0);
    @(posedge clk);
    queue_request('{FUNC_MARK,  10'd128, 10'd128});
    queue_request('{FUNC_CHECK, 10'd128, 10'd128});

    // Largest margin
    wait_drained();
    set_map(256, 256, 63);
    @(posedge clk);
    queue_request('{FUNC_MARK,  10'd100, 10'd100});
    queue_request('{FUNC_CHECK, 10'd162, 10'd162});
    queue_request('{FUNC_CHECK, 10'd163, 10'd100});

    // One column wide map
    wait_drained();
    set_map(1, 256, 1);
    @(posedge clk);
    queue_request('{FUNC_MARK,  10'd500, 10'd200});
    queue_request('{FUNC_CHECK, 10'd0,   10'd201});

    // Shrink, then grow again: cells outside the small map keep their value
    wait_drained();
    set_map(16, 16, 3);
    @(posedge clk);
    queue_request('{FUNC_MARK,  10'd20,   10'd20});
    queue_request('{FUNC_CHECK, 10'd1023, 10'd8});
    wait_drained();
    set_map(256, 256, 2);
    @(posedge clk);
    queue_request('{FUNC_CHECK, 10'd40,  10'd40});
    queue_request('{FUNC_CHECK, 10'd15,  10'd15});
    queue_request('{FUNC_CHECK, 10'd200, 10'd1});

    // Random phases, each with its own map setting
    while (random_reqs < RANDOM_ITEMS) begin
      wait_drained();
      if ($urandom_range(0, 9) == 0) begin
        // large margins only on small maps to bound the marking time
        mv = $urandom_range(13, 63);
        wv = $urandom_range(0, 24);
        hv = $urandom_range(0, 24);
      end else begin
        mv = $urandom_range(0, 8);
        wv = random_extent();
        hv = random_extent();
      end
      set_map(wv, hv, mv);
      @(posedge clk);
      n = $urandom_range(40, 120);
      if (n > RANDOM_ITEMS - random_reqs) n = RANDOM_ITEMS - random_reqs;
      repeat (n) begin
        queue_request(random_request());
        random_reqs++;
      end
    end

    // Drain, then let the block run on so that a stray response is still caught
    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_rsp.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", expected_rsp.size()));

    $display("Run covered %0d requests (%0d checks) over %0d map settings after reset.",
             req_beats, check_reqs, map_settings + 1);
    $display("Areas marked: %0d, requests on occupied centers: %0d, mismatches: %0d.",
             areas_set, blocked_cells, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
